/* hdl/bpsm_pkg.sv */
// Shared types and constants for the buffer pool swap manager.
// No dependencies; every other file of the block but bpsm_ram refers to this package.
`timescale 1ns / 1ps
package bpsm_pkg;

  localparam int HANDLES_DEF = 64;

  localparam int OPCODE_W  = 3;
  localparam int HIDX_W    = 8;
  localparam int LEN_W     = 24;
  localparam int STATUS_W  = 3;
  localparam int HANDLE_W  = 6;
  localparam int FRAME_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int THR_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [OPCODE_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_LEN   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REL_CLEAN = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REL_DIRTY = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FREE      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OFF_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_VALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 7'd64;
  localparam logic [LEN_W-1:0] LEN_RESET = 24'd4096;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [HIDX_W-1:0]   handle_index;
    logic [LEN_W-1:0]    length_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] given_handle;
    logic [FRAME_W-1:0]  bound_frame;
    logic                zero_fill;
    logic                writeback_request;
    logic [HANDLE_W-1:0] writeback_handle;
    logic [FRAME_W-1:0]  writeback_frame;
    logic [LEN_W-1:0]    writeback_length;
    logic                readin_request;
    logic [LEN_W-1:0]    readin_length;
    logic [COUNT_W-1:0]  frames_in_use;
    logic [COUNT_W-1:0]  peak_allocated;
  } out_item_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
    logic commit;
  } cmd_t;

endpackage

/* hdl/buffer_pool_swap_manager_top.sv */
// Top level of the buffer pool swap manager.
// Depends on bpsm_pkg, bpsm_ctrl, bpsm_dp (and bpsm_ram through bpsm_dp).
`timescale 1ns / 1ps
// Usage:
// Input channel (in_valid, in_stall, in_data) carries one command word:
// opcode, handle_index, length_value. It is taken when in_valid is high and
// in_stall is low. Every command gives exactly one result word on the
// output channel (out_valid, out_stall, out_data), held while out_stall is high.
// Each command goes through capture, table lookup of the addressed handle
// together with the victim search, then a second table read of the victim
// and the commit. The frame and length tables have one read port, so the two
// reads are made one after the other; no new command is taken until commit.
// The result enters the output register in the cycle after commit. A result
// stalled there does not block the next command until that command is ready
// to commit; it then waits until the register drains.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken; index 0 threshold, 1 swap enable, 2 default frame length.
// Synchronous reset clears all flags (the release flags it sets), counters and
// the free stack, and restores the configuration defaults; no clearing pass is needed.
module buffer_pool_swap_manager_top #(
  parameter int HANDLES = bpsm_pkg::HANDLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpsm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpsm_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpsm_pkg::LEN_W-1:0]     cfg_data
);

  bpsm_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  bpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bpsm_dp #(.HANDLES(HANDLES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command accepted while another is in flight");

  a_wb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.writeback_request) |-> (out_data.status == bpsm_pkg::ST_OK))
    else $error("write-back reported with a failing status");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a command in flight");

  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.frames_in_use) <= 32'(HANDLES)))
    else $error("frame count exceeds handle count");

endmodule

/* hdl/bpsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bpsm_ctrl.sv */
// Sequencer of the buffer pool swap manager: capture, lookup, execute.
// Depends on bpsm_pkg; drives commands into bpsm_dp.
`timescale 1ns / 1ps
module bpsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output bpsm_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.look    = (state_r == ST_LOOK);
    cmd.exec    = (state_r == ST_EXEC);
    // result register must be empty or draining
    cmd.commit  = cmd.exec && (!out_valid_r || !out_stall);

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/bpsm_dp.sv */
// Datapath of the buffer pool swap manager: flag vectors, counters, tables,
// victim search and result register. Depends on bpsm_pkg and bpsm_ram.
`timescale 1ns / 1ps
module bpsm_dp #(
  parameter int HANDLES = bpsm_pkg::HANDLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpsm_pkg::cmd_t                      cmd,
  input  bpsm_pkg::in_item_t                  in_data,
  output bpsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpsm_pkg::LEN_W-1:0]          cfg_data
);

  localparam int HW = $clog2(HANDLES);
  localparam int CW = $clog2(HANDLES + 1);
  localparam int FW = bpsm_pkg::FRAME_W;
  localparam int LW = bpsm_pkg::LEN_W;
  localparam int GW = bpsm_pkg::HANDLE_W;
  localparam int OW = bpsm_pkg::COUNT_W;
  localparam int TW = bpsm_pkg::THR_W;

  // configuration
  logic [TW-1:0] thr_r;
  logic          swap_r;
  logic [LW-1:0] flen_r;

  // captured item
  logic [bpsm_pkg::OPCODE_W-1:0] op_r;
  logic [bpsm_pkg::HIDX_W-1:0]   h_r;
  logic [LW-1:0]                 len_r;

  logic [HANDLES-1:0] valid_r, dirty_r, rel_r, fresh_r, bound_r;
  logic [HANDLES-1:0] valid_nxt, dirty_nxt, rel_nxt, fresh_nxt, bound_nxt;
  logic [CW-1:0] head_r, wm_r, alloc_r, fc_r, peak_r;
  logic [CW-1:0] head_nxt, wm_nxt, alloc_nxt, fc_nxt, peak_nxt;

  logic [FW-1:0] frame_h_r;
  logic [LW-1:0] len_h_r;
  logic [HW-1:0] vic_r;
  logic          clean_found_r, any_found_r;

  bpsm_pkg::out_item_t out_r, res;

  // table ports
  logic          fram_we, lram_we, link_we;
  logic [HW-1:0] fram_wa, lram_wa, link_wa, tbl_ra;
  logic [FW-1:0] fram_wd, fram_rd;
  logic [LW-1:0] lram_wd, lram_rd;
  logic [CW-1:0] link_wd, link_rd;

  // victim search
  logic [HANDLES-1:0] clean_v, any_v;
  logic [HW-1:0]      first_clean, last_any, vic_sel;
  logic               clean_found, any_found;

  logic [HW-1:0] hi;
  logic          off_range, take_new, steal;
  logic [LW-1:0] len_h_eff, len_v_eff;

  bpsm_ram #(.WIDTH(FW), .DEPTH(HANDLES)) u_frame_ram (
    .clk(clk), .we(fram_we), .waddr(fram_wa), .wdata(fram_wd),
    .raddr(tbl_ra), .rdata(fram_rd)
  );

  bpsm_ram #(.WIDTH(LW), .DEPTH(HANDLES)) u_len_ram (
    .clk(clk), .we(lram_we), .waddr(lram_wa), .wdata(lram_wd),
    .raddr(tbl_ra), .rdata(lram_rd)
  );

  bpsm_ram #(.WIDTH(CW), .DEPTH(HANDLES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(HW'(head_r)), .rdata(link_rd)
  );

  // read the item's handle on capture, then the victim
  assign tbl_ra = cmd.look ? vic_sel : (cmd.exec ? vic_r : HW'(in_data.handle_index));

  always_comb begin
    clean_v     = rel_r & bound_r & ~dirty_r;
    any_v       = rel_r & bound_r;
    first_clean = '0;
    clean_found = 1'b0;
    last_any    = '0;
    any_found   = 1'b0;
    for (int i = HANDLES - 1; i >= 0; i--) begin
      if (clean_v[i]) begin
        first_clean = HW'(i);
        clean_found = 1'b1;
      end
    end
    for (int i = 0; i < HANDLES; i++) begin
      if (any_v[i]) begin
        last_any  = HW'(i);
        any_found = 1'b1;
      end
    end
    vic_sel = clean_found ? first_clean : last_any;
  end

  assign hi        = HW'(h_r);
  assign off_range = (32'(h_r) >= 32'(HANDLES));
  assign len_h_eff = (len_h_r == '0) ? flen_r : len_h_r;
  assign len_v_eff = (lram_rd == '0) ? flen_r : lram_rd;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    rel_nxt   = rel_r;
    fresh_nxt = fresh_r;
    bound_nxt = bound_r;
    head_nxt  = head_r;
    wm_nxt    = wm_r;
    alloc_nxt = alloc_r;
    fc_nxt    = fc_r;
    peak_nxt  = peak_r;
    fram_we   = 1'b0;
    fram_wa   = hi;
    fram_wd   = frame_h_r;
    lram_we   = 1'b0;
    lram_wa   = hi;
    lram_wd   = len_r;
    link_we   = 1'b0;
    link_wa   = hi;
    link_wd   = head_r;
    take_new  = 1'b0;
    steal     = 1'b0;
    res       = '0;
    res.status = bpsm_pkg::ST_OK;

    case (op_r)
      bpsm_pkg::OP_ALLOC: begin
        if ((32'(alloc_r) < 32'(HANDLES)) && (32'(head_r) < 32'(HANDLES))) begin
          res.given_handle = GW'(head_r);
          // untouched handles chain to the next index
          if (head_r == wm_r) begin
            head_nxt = CW'(head_r + 1'b1);
            wm_nxt   = CW'(wm_r + 1'b1);
          end else begin
            head_nxt = link_rd;
          end
          alloc_nxt = CW'(alloc_r + 1'b1);
          if (alloc_nxt > peak_r) peak_nxt = alloc_nxt;
          dirty_nxt[HW'(head_r)] = 1'b1;
          valid_nxt[HW'(head_r)] = 1'b1;
          fresh_nxt[HW'(head_r)] = 1'b1;
          lram_we = 1'b1;
          lram_wa = HW'(head_r);
          lram_wd = '0;
        end else begin
          res.status = bpsm_pkg::ST_POOL_FULL;
        end
      end
      bpsm_pkg::OP_SET_LEN: begin
        if (off_range) res.status = bpsm_pkg::ST_OFF_RANGE;
        else lram_we = 1'b1;
      end
      bpsm_pkg::OP_FREE: begin
        if (off_range) begin
          res.status = bpsm_pkg::ST_OFF_RANGE;
        end else if (!valid_r[hi]) begin
          res.status = bpsm_pkg::ST_NOT_VALID;
        end else begin
          alloc_nxt     = CW'(alloc_r - 1'b1);
          link_we       = 1'b1;
          head_nxt      = CW'(h_r);
          rel_nxt[hi]   = 1'b1;
          dirty_nxt[hi] = 1'b0;
          valid_nxt[hi] = 1'b0;
        end
      end
      bpsm_pkg::OP_REL_CLEAN, bpsm_pkg::OP_REL_DIRTY: begin
        if (off_range) begin
          res.status = bpsm_pkg::ST_OFF_RANGE;
        end else if (!valid_r[hi]) begin
          res.status = bpsm_pkg::ST_NOT_VALID;
        end else if (!bound_r[hi]) begin
          res.status = bpsm_pkg::ST_NO_FRAME;
        end else begin
          rel_nxt[hi] = 1'b1;
          if (op_r == bpsm_pkg::OP_REL_DIRTY) dirty_nxt[hi] = 1'b1;
        end
      end
      bpsm_pkg::OP_LOAD: begin
        if (off_range) begin
          res.status = bpsm_pkg::ST_OFF_RANGE;
        end else if (!valid_r[hi]) begin
          res.status = bpsm_pkg::ST_NOT_VALID;
        end else if (bound_r[hi]) begin
          rel_nxt[hi] = 1'b0;
          if (fresh_r[hi]) begin
            fresh_nxt[hi] = 1'b0;
            res.zero_fill = 1'b1;
          end
          res.bound_frame = frame_h_r;
        end else if (32'(fc_r) < 32'(thr_r)) begin
          take_new = 1'b1;
        end else begin
          if (clean_found_r) begin
            steal = 1'b1;
          end else if (swap_r && any_found_r) begin
            steal = 1'b1;
            res.writeback_request = 1'b1;
            res.writeback_handle  = GW'(vic_r);
            res.writeback_frame   = fram_rd;
            res.writeback_length  = len_v_eff;
            dirty_nxt[vic_r]      = 1'b0;
          end
          if (steal) begin
            fram_we          = 1'b1;
            fram_wd          = fram_rd;
            bound_nxt[hi]    = 1'b1;
            rel_nxt[hi]      = 1'b0;
            bound_nxt[vic_r] = 1'b0;
            if (fresh_r[hi]) begin
              fresh_nxt[hi] = 1'b0;
              res.zero_fill = 1'b1;
            end
            res.bound_frame = fram_rd;
          end else begin
            take_new = 1'b1;
          end
          // the loading handle is never the victim, so its dirty bit holds
          if (swap_r && !dirty_r[hi]) begin
            res.readin_request = 1'b1;
            res.readin_length  = len_h_eff;
          end
        end
        if (take_new) begin
          fram_we         = 1'b1;
          fram_wd         = FW'(fc_r);
          fc_nxt          = CW'(fc_r + 1'b1);
          bound_nxt[hi]   = 1'b1;
          rel_nxt[hi]     = 1'b0;
          fresh_nxt[hi]   = 1'b0;
          res.zero_fill   = 1'b1;
          res.bound_frame = FW'(fc_r);
        end
      end
      default: ;
    endcase

    res.frames_in_use  = OW'(fc_nxt);
    res.peak_allocated = OW'(peak_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= bpsm_pkg::THR_RESET;
      swap_r  <= 1'b1;
      flen_r  <= bpsm_pkg::LEN_RESET;
      valid_r <= '0;
      dirty_r <= '0;
      rel_r   <= '1;
      fresh_r <= '0;
      bound_r <= '0;
      head_r  <= '0;
      wm_r    <= '0;
      alloc_r <= '0;
      fc_r    <= '0;
      peak_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpsm_pkg::CFG_THRESHOLD: thr_r  <= cfg_data[TW-1:0];
          bpsm_pkg::CFG_SWAP:      swap_r <= cfg_data[0];
          bpsm_pkg::CFG_FRAME_LEN: flen_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        dirty_r <= dirty_nxt;
        rel_r   <= rel_nxt;
        fresh_r <= fresh_nxt;
        bound_r <= bound_nxt;
        head_r  <= head_nxt;
        wm_r    <= wm_nxt;
        alloc_r <= alloc_nxt;
        fc_r    <= fc_nxt;
        peak_r  <= peak_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.opcode;
      h_r   <= in_data.handle_index;
      len_r <= in_data.length_value;
    end
    if (cmd.look) begin
      frame_h_r     <= fram_rd;
      len_h_r       <= lram_rd;
      vic_r         <= vic_sel;
      clean_found_r <= clean_found;
      any_found_r   <= any_found;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

/* dv/tb_buffer_pool_swap_manager_top.sv */
// Self-checking testbench for buffer_pool_swap_manager_top: directed and random
// command words checked against a pool predictor held in a scoreboard class.
// Depends on bpsm_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_buffer_pool_swap_manager_top;

  localparam int NH  = bpsm_pkg::HANDLES_DEF;
  localparam int OPW = bpsm_pkg::OPCODE_W;
  localparam int LW  = bpsm_pkg::LEN_W;

  class pool_scoreboard;
    bit [bpsm_pkg::THR_W-1:0]   threshold;
    bit                         swap_on;
    bit [bpsm_pkg::LEN_W-1:0]   def_len;
    bit                         valid_f[NH], dirty_f[NH], rel_f[NH], fresh_f[NH], bound_f[NH];
    bit [bpsm_pkg::FRAME_W-1:0] frame_tab[NH];
    bit [bpsm_pkg::LEN_W-1:0]   len_tab[NH];
    int                         link_tab[NH];
    int                         head, alloc_cnt, frame_cnt, peak_cnt;
    bpsm_pkg::out_item_t        pending[$];
    int                         errors, checked, writebacks, readins, full_hits;

    function new();
      threshold = bpsm_pkg::THR_RESET;
      swap_on = 1'b1;
      def_len = bpsm_pkg::LEN_RESET;
      for (int i = 0; i < NH; i++) begin
        valid_f[i] = 0; dirty_f[i] = 0; rel_f[i] = 1; fresh_f[i] = 0; bound_f[i] = 0;
        frame_tab[i] = '0; len_tab[i] = '0; link_tab[i] = i + 1;
      end
      head = 0; alloc_cnt = 0; frame_cnt = 0; peak_cnt = 0;
      errors = 0; checked = 0; writebacks = 0; readins = 0; full_hits = 0;
    endfunction

    function void set_register(logic [bpsm_pkg::CFG_IDX_W-1:0] idx,
                               logic [bpsm_pkg::LEN_W-1:0] val);
      if (idx == bpsm_pkg::CFG_THRESHOLD) threshold = val[bpsm_pkg::THR_W-1:0];
      else if (idx == bpsm_pkg::CFG_SWAP) swap_on = val[0];
      else if (idx == bpsm_pkg::CFG_FRAME_LEN) def_len = val;
    endfunction

    function bit [bpsm_pkg::LEN_W-1:0] used_len(int h);
      return (len_tab[h] != 0) ? len_tab[h] : def_len;
    endfunction

    function bit [bpsm_pkg::FRAME_W-1:0] take_new_frame();
      take_new_frame = frame_cnt[bpsm_pkg::FRAME_W-1:0];
      frame_cnt++;
    endfunction

    function void note_command(bpsm_pkg::in_item_t w);
      bpsm_pkg::out_item_t r;
      int h, first_clean, last_any;
      bit found;
      r = '0;
      h = w.handle_index;
      if (w.opcode == bpsm_pkg::OP_ALLOC) begin
        if (alloc_cnt < NH && head < NH) begin
          r.given_handle = head[bpsm_pkg::HANDLE_W-1:0];
          h = head;
          head = link_tab[h];
          alloc_cnt++;
          if (alloc_cnt > peak_cnt) peak_cnt = alloc_cnt;
          dirty_f[h] = 1; len_tab[h] = '0; valid_f[h] = 1; fresh_f[h] = 1;
        end else begin
          r.status = bpsm_pkg::ST_POOL_FULL;
          full_hits++;
        end
      end else if (w.opcode <= bpsm_pkg::OP_FREE) begin
        if (h >= NH) r.status = bpsm_pkg::ST_OFF_RANGE;
        else if (w.opcode == bpsm_pkg::OP_SET_LEN) len_tab[h] = w.length_value;
        else if (w.opcode == bpsm_pkg::OP_FREE) begin
          if (!valid_f[h]) r.status = bpsm_pkg::ST_NOT_VALID;
          else begin
            alloc_cnt--;
            link_tab[h] = head; head = h;
            rel_f[h] = 1; dirty_f[h] = 0; valid_f[h] = 0;
          end
        end else if (!valid_f[h]) r.status = bpsm_pkg::ST_NOT_VALID;
        else if (w.opcode == bpsm_pkg::OP_REL_CLEAN || w.opcode == bpsm_pkg::OP_REL_DIRTY) begin
          if (!bound_f[h]) r.status = bpsm_pkg::ST_NO_FRAME;
          else begin
            rel_f[h] = 1;
            if (w.opcode == bpsm_pkg::OP_REL_DIRTY) dirty_f[h] = 1;
          end
        end else begin
          if (bound_f[h]) begin
            rel_f[h] = 0;
            if (fresh_f[h]) begin fresh_f[h] = 0; r.zero_fill = 1; end
          end else if (frame_cnt < threshold) begin
            frame_tab[h] = take_new_frame();
            bound_f[h] = 1; rel_f[h] = 0; fresh_f[h] = 0; r.zero_fill = 1;
          end else begin
            first_clean = NH; last_any = NH; found = 0;
            for (int i = 0; i < NH; i++) begin
              if (!found && rel_f[i] && bound_f[i]) begin
                last_any = i;
                if (!dirty_f[i]) begin first_clean = i; found = 1; end
              end
            end
            if (swap_on && first_clean == NH && last_any < NH) begin
              r.writeback_request = 1;
              r.writeback_handle = last_any[bpsm_pkg::HANDLE_W-1:0];
              r.writeback_frame = frame_tab[last_any];
              r.writeback_length = used_len(last_any);
              dirty_f[last_any] = 0;
              first_clean = last_any;
              writebacks++;
            end
            if (first_clean == NH) begin
              frame_tab[h] = take_new_frame();
              bound_f[h] = 1; fresh_f[h] = 0; rel_f[h] = 0; r.zero_fill = 1;
            end else begin
              frame_tab[h] = frame_tab[first_clean];
              bound_f[h] = 1; rel_f[h] = 0; bound_f[first_clean] = 0;
              if (fresh_f[h]) begin fresh_f[h] = 0; r.zero_fill = 1; end
            end
            if (swap_on && !dirty_f[h]) begin
              r.readin_request = 1;
              r.readin_length = used_len(h);
              readins++;
            end
          end
          r.bound_frame = frame_tab[h];
        end
      end
      r.frames_in_use = frame_cnt[bpsm_pkg::COUNT_W-1:0];
      r.peak_allocated = peak_cnt[bpsm_pkg::COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function string show(bpsm_pkg::out_item_t r);
      string s;
      s = $sformatf("st=%0d gh=%0d bf=%0d zf=%0d",
                    r.status, r.given_handle, r.bound_frame, r.zero_fill);
      s = {s, $sformatf(" wb=%0d/%0d/%0d/%0d", r.writeback_request, r.writeback_handle,
                        r.writeback_frame, r.writeback_length)};
      s = {s, $sformatf(" rd=%0d/%0d fr=%0d pk=%0d", r.readin_request, r.readin_length,
                        r.frames_in_use, r.peak_allocated)};
      return s;
    endfunction

    function void check_result(bpsm_pkg::out_item_t got);
      bpsm_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got !== exp_r) begin
        errors++;
        $display("%0t: mismatch expected %s", $time, show(exp_r));
        $display("%0t:          actual   %s", $time, show(got));
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  bpsm_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bpsm_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bpsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpsm_pkg::LEN_W-1:0]     cfg_data = '0;

  pool_scoreboard pool = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int sent = 0;

  always #2 clk = ~clk;

  buffer_pool_swap_manager_top dut (.*);

  // Receiver: check accepted words, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pool.check_result(out_data);
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(bpsm_pkg::in_item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pool.note_command(w);
    sent++;
  endtask

  task automatic write_register(logic [bpsm_pkg::CFG_IDX_W-1:0] idx,
                                logic [bpsm_pkg::LEN_W-1:0] val);
    in_valid <= 1'b0;
    while (pool.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool.set_register(idx, val);
  endtask

  function automatic bpsm_pkg::in_item_t make_word(logic [bpsm_pkg::OPCODE_W-1:0] op, int h,
                                                   logic [bpsm_pkg::LEN_W-1:0] len);
    bpsm_pkg::in_item_t w;
    w.opcode = op;
    w.handle_index = h[bpsm_pkg::HIDX_W-1:0];
    w.length_value = len;
    return w;
  endfunction

  function automatic int pick_handle();
    int start;
    if ($urandom_range(99) < 85 && pool.alloc_cnt > 0) begin
      start = $urandom_range(NH - 1);
      for (int i = 0; i < NH; i++)
        if (pool.valid_f[(start + i) % NH]) return (start + i) % NH;
    end
    return $urandom_range(NH - 1);
  endfunction

  function automatic logic [bpsm_pkg::LEN_W-1:0] pick_len();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return LW'($urandom_range(64, 1));
      default: return LW'($urandom);
    endcase
  endfunction

  function automatic bpsm_pkg::in_item_t random_word(int alloc_w);
    int r;
    r = $urandom_range(99);
    if (r < 4) return make_word(OPW'($urandom_range(7, 6)), $urandom_range(255), LW'($urandom));
    if (r < 8) return make_word(OPW'($urandom_range(5, 1)), $urandom_range(255, NH),
                                LW'($urandom));
    r = $urandom_range(99);
    if (r < alloc_w) return make_word(bpsm_pkg::OP_ALLOC, $urandom_range(255), LW'($urandom));
    r = $urandom_range(99);
    if (r < 12) return make_word(bpsm_pkg::OP_SET_LEN, pick_handle(), pick_len());
    if (r < 55) return make_word(bpsm_pkg::OP_LOAD, pick_handle(), LW'($urandom));
    if (r < 70) return make_word(bpsm_pkg::OP_REL_CLEAN, pick_handle(), LW'($urandom));
    if (r < 85) return make_word(bpsm_pkg::OP_REL_DIRTY, pick_handle(), LW'($urandom));
    return make_word(bpsm_pkg::OP_FREE, pick_handle(), LW'($urandom));
  endfunction

  task automatic random_phase(int count, int alloc_w);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2 && alloc_w < 50) hold_off = 300;
      send_word(random_word(pool.alloc_cnt > 52 ? 5 : alloc_w));
    end
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: special cases and field extremes
    send_word(make_word(bpsm_pkg::OP_LOAD, 0, '0));
    send_word(make_word(bpsm_pkg::OP_ALLOC, 255, '1));
    send_word(make_word(bpsm_pkg::OP_ALLOC, 0, '0));
    send_word(make_word(bpsm_pkg::OP_REL_CLEAN, 0, '0));
    send_word(make_word(bpsm_pkg::OP_SET_LEN, 63, '1));
    send_word(make_word(bpsm_pkg::OP_SET_LEN, 1, 24'd1));
    send_word(make_word(bpsm_pkg::OP_LOAD, 0, '0));
    send_word(make_word(bpsm_pkg::OP_LOAD, 0, '0));
    send_word(make_word(bpsm_pkg::OP_LOAD, 1, '0));
    send_word(make_word(bpsm_pkg::OP_REL_DIRTY, 1, '0));
    send_word(make_word(bpsm_pkg::OP_REL_CLEAN, 0, '0));
    send_word(make_word(bpsm_pkg::OP_FREE, 5, '0));
    send_word(make_word(bpsm_pkg::OP_FREE, 0, '0));
    send_word(make_word(bpsm_pkg::OP_LOAD, 255, '0));
    send_word(make_word(bpsm_pkg::OP_SET_LEN, NH, '1));
    send_word(make_word(3'd6, 0, '0));
    send_word(make_word(3'd7, 170, 24'h555555));
    send_word(make_word(bpsm_pkg::OP_ALLOC, 0, '0));

    // steal at threshold zero with swap, then without swap
    write_register(bpsm_pkg::CFG_THRESHOLD, '0);
    write_register(bpsm_pkg::CFG_FRAME_LEN, '0);
    send_word(make_word(bpsm_pkg::OP_LOAD, 0, '0));
    send_word(make_word(bpsm_pkg::OP_REL_DIRTY, 0, '0));
    send_word(make_word(bpsm_pkg::OP_LOAD, 1, '0));
    write_register(bpsm_pkg::CFG_SWAP, '0);
    send_word(make_word(bpsm_pkg::OP_REL_DIRTY, 1, '0));
    send_word(make_word(bpsm_pkg::OP_LOAD, 0, '0));

    send_idle_pct = 34; recv_stall_pct = 85;
    write_register(bpsm_pkg::CFG_THRESHOLD, 24'd4);
    write_register(bpsm_pkg::CFG_SWAP, 24'd1);
    write_register(bpsm_pkg::CFG_FRAME_LEN, 24'd1);
    random_phase(250, 60);
    random_phase(100, 15);

    send_idle_pct = 85; recv_stall_pct = 34;
    write_register(bpsm_pkg::CFG_THRESHOLD, 24'd64);
    write_register(bpsm_pkg::CFG_FRAME_LEN, '1);
    random_phase(350, 20);

    send_idle_pct = 0; recv_stall_pct = 0;
    write_register(bpsm_pkg::CFG_THRESHOLD, 24'd127);
    write_register(bpsm_pkg::CFG_SWAP, '0);
    random_phase(200, 20);
    write_register(bpsm_pkg::CFG_THRESHOLD, '0);
    write_register(bpsm_pkg::CFG_SWAP, 24'd1);
    write_register(bpsm_pkg::CFG_FRAME_LEN, bpsm_pkg::LEN_RESET);
    random_phase(300, 18);
    write_register(bpsm_pkg::CFG_THRESHOLD, 24'd10);
    write_register(bpsm_pkg::CFG_FRAME_LEN, 24'd77);
    random_phase(200, 25);

    in_valid <= 1'b0;
    while (pool.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d command words, checked %0d results: %0d write-backs, %0d read-ins,",
             sent, pool.checked, pool.writebacks, pool.readins);
    $display("%0d pool-full allocates, %0d frames created, peak %0d handles held.",
             pool.full_hits, pool.frame_cnt, pool.peak_cnt);
    if (pool.errors == 0 && pool.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bpsm_pkg.sv
hdl/bpsm_ram.sv
hdl/bpsm_ctrl.sv
hdl/bpsm_dp.sv
hdl/buffer_pool_swap_manager_top.sv
dv/tb_buffer_pool_swap_manager_top.sv
